>>> rtl/core/bb3_pkg.sv
`timescale 1ns / 1ps

package bb3_pkg;

    // Frame limits and the widths that follow from them.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int OUT_ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);

    // Register port.
    localparam int CFG_WID_W = 11;
    localparam int CFG_HGT_W = 13;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_SEL_LSB = 2;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;
    localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = CFG_WID_W'(640);
    localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = CFG_HGT_W'(480);

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Arithmetic widths.
    localparam int CHAN_W      = 8;
    localparam int ROW_SUM_W   = 10;
    localparam int SUM_W       = 12;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Rounded-up reciprocals; exact for every sum of up to nine 8-bit values.
    localparam int RECIP_D1 = 2 ** RECIP_SHIFT;
    localparam int RECIP_D2 = (2 ** RECIP_SHIFT + 1) / 2;
    localparam int RECIP_D3 = (2 ** RECIP_SHIFT + 2) / 3;
    localparam int RECIP_D4 = (2 ** RECIP_SHIFT + 3) / 4;
    localparam int RECIP_D6 = (2 ** RECIP_SHIFT + 5) / 6;
    localparam int RECIP_D9 = (2 ** RECIP_SHIFT + 8) / 9;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        t_pix upper;
        t_pix middle;
    } t_line_pair;

    typedef struct packed {
        logic row_top;
        logic row_bot;
        logic col_lft;
        logic col_rgt;
        logic last;
    } t_edge;

    // Window rows run top to bottom, columns left to right.
    typedef struct packed {
        t_pix [2:0][2:0] win;
        t_edge           edges;
    } t_win_item;

    function automatic logic [RECIP_W-1:0] f_recip(input logic [3:0] cnt);
        logic [RECIP_W-1:0] m;
        unique case (cnt)
            4'd1:    m = RECIP_W'(RECIP_D1);
            4'd2:    m = RECIP_W'(RECIP_D2);
            4'd3:    m = RECIP_W'(RECIP_D3);
            4'd4:    m = RECIP_W'(RECIP_D4);
            4'd6:    m = RECIP_W'(RECIP_D6);
            4'd9:    m = RECIP_W'(RECIP_D9);
            default: m = RECIP_W'(RECIP_D1);
        endcase
        return m;
    endfunction

endpackage

>>> rtl/core/box_blur_3x3_edge_mean_unit.sv
`timescale 1ns / 1ps

// 3x3 box blur of an RGB frame streamed in raster order. Each pixel leaves as
// the truncated mean of its in-frame neighbors (9 inside, 6 on an edge, 4 in a
// corner, fewer for one-pixel-wide or one-pixel-high frames). The result for
// pixel (r,c) is released by the item that carries pixel (r+1,c+1) in raster
// order, so after the last pixel of a frame the user pushes frame_width + 1
// items with drain set to flush the remaining results. A drain item before the
// last pixel is ignored, and a pixel pushed during the flush is dropped and
// acts as a drain. The block takes one item per clock while full is low and
// gives one result per clock while pop is held, set by the line store, which
// does one read and one write each cycle; a result passes the line-store stage,
// the queue and the back end. last_of_frame marks the final result of a frame,
// after which the next pixel starts a new frame. Writing frame_width (offset
// 0x0) or frame_height (offset 0x4) restarts the frame; a size of zero counts
// as one, and larger sizes saturate at 1024 by 4096. The line store needs no
// clearing after reset, so items are taken from the first cycle.
module box_blur_3x3_edge_mean_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   i_in_red,
    input  logic [7:0]                   i_in_green,
    input  logic [7:0]                   i_in_blue,
    input  logic                         i_drain,
    output logic                         empty,
    input  logic                         pop,
    output logic [7:0]                   o_out_red,
    output logic [7:0]                   o_out_green,
    output logic [7:0]                   o_out_blue,
    output logic                         o_last_of_frame,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bb3_pkg::PADDR_W-1:0]  paddr,
    input  logic [bb3_pkg::PDATA_W-1:0]  pwdata,
    output logic [bb3_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import bb3_pkg::*;

    logic [CFG_WID_W-1:0] r_width_raw;
    logic [CFG_HGT_W-1:0] r_height_raw;
    logic [WID_W-1:0]     r_width, n_width;
    logic [HGT_W-1:0]     r_height, n_height;
    logic [CFG_WID_W-1:0] wr_width;
    logic [CFG_HGT_W-1:0] wr_height;
    logic                 cfg_wr, cfg_sel;

    t_pix      in_pix, out_pix;
    t_win_item q_in_item, q_out_item;
    logic      q_push, q_pop, q_empty;
    logic [QCNT_W-1:0] q_count;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[REG_SEL_LSB];

    assign wr_width  = pwdata[CFG_WID_W-1:0];
    assign wr_height = pwdata[CFG_HGT_W-1:0];

    always_comb begin
        if (wr_width == '0) begin
            n_width = WID_W'(1);
        end else if (wr_width > CFG_WID_W'(MAX_WIDTH)) begin
            n_width = WID_W'(MAX_WIDTH);
        end else begin
            n_width = WID_W'(wr_width);
        end
        if (wr_height == '0) begin
            n_height = HGT_W'(1);
        end else if (wr_height > CFG_HGT_W'(MAX_HEIGHT)) begin
            n_height = HGT_W'(MAX_HEIGHT);
        end else begin
            n_height = HGT_W'(wr_height);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_raw  <= WIDTH_RESET;
            r_height_raw <= HEIGHT_RESET;
            r_width      <= WID_W'(WIDTH_RESET);
            r_height     <= HGT_W'(HEIGHT_RESET);
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_FRAME_WIDTH: begin
                    r_width_raw <= wr_width;
                    r_width     <= n_width;
                end
                REG_FRAME_HEIGHT: begin
                    r_height_raw <= wr_height;
                    r_height     <= n_height;
                end
                default: begin
                    r_width_raw <= r_width_raw;
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(r_width_raw);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(r_height_raw);
            default:          prdata = '0;
        endcase
    end

    assign in_pix.red   = i_in_red;
    assign in_pix.green = i_in_green;
    assign in_pix.blue  = i_in_blue;

    bb3_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_wr),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_push    (push),
        .i_pix     (in_pix),
        .i_drain   (i_drain),
        .o_full    (full),
        .i_q_count (q_count),
        .o_q_push  (q_push),
        .o_q_item  (q_in_item)
    );

    bb3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .i_pop   (q_pop),
        .o_item  (q_out_item),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    bb3_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_item  (q_out_item),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_pix     (out_pix),
        .o_last    (o_last_of_frame),
        .o_empty   (empty),
        .i_pop     (pop)
    );

    assign o_out_red   = out_pix.red;
    assign o_out_green = out_pix.green;
    assign o_out_blue  = out_pix.blue;

endmodule

>>> rtl/core/bb3_front.sv
`timescale 1ns / 1ps

module bb3_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_restart,
    input  logic [bb3_pkg::WID_W-1:0]    i_width,
    input  logic [bb3_pkg::HGT_W-1:0]    i_height,
    input  logic                         i_push,
    input  bb3_pkg::t_pix                i_pix,
    input  logic                         i_drain,
    output logic                         o_full,
    input  logic [bb3_pkg::QCNT_W-1:0]   i_q_count,
    output logic                         o_q_push,
    output bb3_pkg::t_win_item           o_q_item
);
    import bb3_pkg::*;

    logic [COL_W-1:0]     r_in_col, n_in_col;
    logic [HGT_W-1:0]     r_in_row, n_in_row;
    logic [COL_W-1:0]     r_out_col, n_out_col;
    logic [OUT_ROW_W-1:0] r_out_row, n_out_row;

    logic  accept, in_done, act, emit, col_wrap, inflight;
    t_pix  pix;
    t_edge edges;

    logic       r_s1_v;
    logic       r_s1_emit;
    t_pix       r_s1_pix;
    logic [COL_W-1:0] r_s1_addr;
    t_edge      r_s1_edges;

    t_line_pair r_line_mem [MAX_WIDTH];
    t_line_pair r_mem_q, r_byp_data, rd_pair, wr_pair;
    logic       r_byp;

    t_pix [2:0][2:0] r_win, n_win;
    t_pix [2:0]      col_vec;

    // Room is reserved for an item still in the line-store stage.
    assign inflight = r_s1_v && r_s1_emit;
    assign o_full   = ((QCNT_W+1)'(i_q_count) + (QCNT_W+1)'(inflight))
                      >= (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept   = i_push && !o_full;

    // A drain before the last pixel does nothing; a pixel after it counts as a drain.
    assign in_done = r_in_row >= i_height;
    assign act     = accept && !(i_drain && !in_done);
    assign pix     = in_done ? '0 : i_pix;
    assign emit    = (r_in_row > HGT_W'(1)) || (r_in_row == HGT_W'(1) && r_in_col != '0);

    assign edges.row_top = r_out_row != '0;
    assign edges.row_bot = (HGT_W'(r_out_row) + HGT_W'(1)) < i_height;
    assign edges.col_lft = r_out_col != '0;
    assign edges.col_rgt = (WID_W'(r_out_col) + WID_W'(1)) < i_width;
    assign edges.last    = !edges.row_bot && !edges.col_rgt;
    assign col_wrap      = (WID_W'(r_in_col) + WID_W'(1)) >= i_width;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        priority if (i_restart || (act && emit && edges.last)) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (act) begin
            if (col_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + HGT_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (emit) begin
                if (!edges.col_rgt) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + OUT_ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_s1_v    <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_s1_v    <= act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (act) begin
            r_s1_emit  <= emit;
            r_s1_pix   <= pix;
            r_s1_addr  <= r_in_col;
            r_s1_edges <= edges;
        end
    end

    // Line store pair: read when an item enters, written back in the next cycle.
    // With a one-pixel row the next item reads the entry being written, so it
    // takes the write data instead.
    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_line_mem[r_s1_addr] <= wr_pair;
        end
        if (act) begin
            r_mem_q    <= r_line_mem[r_in_col];
            r_byp      <= r_s1_v && (r_s1_addr == r_in_col);
            r_byp_data <= wr_pair;
        end
    end

    assign rd_pair        = r_byp ? r_byp_data : r_mem_q;
    assign wr_pair.upper  = rd_pair.middle;
    assign wr_pair.middle = r_s1_pix;

    assign col_vec[0] = rd_pair.upper;
    assign col_vec[1] = rd_pair.middle;
    assign col_vec[2] = r_s1_pix;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
            n_win[r][2] = col_vec[r];
        end
    end

    // Window contents left over from a previous frame are always masked out.
    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_win <= n_win;
        end
    end

    assign o_q_push       = r_s1_v && r_s1_emit;
    assign o_q_item.win   = n_win;
    assign o_q_item.edges = r_s1_edges;

    a_out_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WID_W'(r_out_col) < i_width)
        else $error("output column beyond frame width");

    a_out_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        HGT_W'(r_out_row) < i_height)
        else $error("output row beyond frame height");

    a_frame_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (act && emit && edges.last) |=>
        (r_in_col == '0 && r_in_row == '0 && r_out_col == '0 && r_out_row == '0))
        else $error("counters not cleared after last pixel of frame");

endmodule

>>> rtl/core/bb3_fifo.sv
`timescale 1ns / 1ps

module bb3_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  bb3_pkg::t_win_item          i_item,
    input  logic                        i_pop,
    output bb3_pkg::t_win_item          o_item,
    output logic                        o_empty,
    output logic [bb3_pkg::QCNT_W-1:0]  o_count
);
    import bb3_pkg::*;

    t_win_item         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] f_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= f_next(r_wp);
            end
            if (i_pop) begin
                r_rp <= f_next(r_rp);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rp];
    assign o_empty = r_count == '0;
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != QCNT_W'(QUEUE_DEPTH)))
        else $error("window queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("window queue read while empty");

endmodule

>>> rtl/core/bb3_back.sv
`timescale 1ns / 1ps

module bb3_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bb3_pkg::t_win_item i_q_item,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    output bb3_pkg::t_pix      o_pix,
    output logic               o_last,
    output logic               o_empty,
    input  logic               i_pop
);
    import bb3_pkg::*;

    logic [2:0] row_ok, col_ok;
    logic [1:0] rows_n, cols_n;
    logic [3:0] cnt;

    logic [2:0][2:0][ROW_SUM_W-1:0] n_rsum, r_b1_rsum;   // [channel][row]
    logic [RECIP_W-1:0]             r_b1_recip;
    logic                           r_b1_last, r_b1_v;

    logic [2:0][SUM_W-1:0]          n_total, r_b2_total;
    logic [RECIP_W-1:0]             r_b2_recip;
    logic                           r_b2_last, r_b2_v;

    logic [2:0][PROD_W-1:0]         prod;
    logic [2:0][CHAN_W-1:0]         quot;
    t_pix                           r_b3_pix;
    logic                           r_b3_last, r_b3_v;

    logic b1_rdy, b2_rdy, b3_rdy;

    assign row_ok = {i_q_item.edges.row_bot, 1'b1, i_q_item.edges.row_top};
    assign col_ok = {i_q_item.edges.col_rgt, 1'b1, i_q_item.edges.col_lft};
    assign rows_n = 2'd1 + {1'b0, i_q_item.edges.row_top} + {1'b0, i_q_item.edges.row_bot};
    assign cols_n = 2'd1 + {1'b0, i_q_item.edges.col_lft} + {1'b0, i_q_item.edges.col_rgt};
    assign cnt    = 4'(rows_n) * 4'(cols_n);

    // Channel 0 is blue, 1 green, 2 red, as packed in a pixel.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
                n_rsum[ch][r] = '0;
                for (int c = 0; c < 3; c++) begin
                    if (row_ok[r] && col_ok[c]) begin
                        n_rsum[ch][r] = n_rsum[ch][r]
                            + ROW_SUM_W'(i_q_item.win[r][c][CHAN_W*ch +: CHAN_W]);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_total[ch] = SUM_W'(r_b1_rsum[ch][0]) + SUM_W'(r_b1_rsum[ch][1])
                        + SUM_W'(r_b1_rsum[ch][2]);
        end
    end

    // Divide by the neighbor count as a multiply by its reciprocal.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = PROD_W'(r_b2_total[ch]) * PROD_W'(r_b2_recip);
            quot[ch] = prod[ch][RECIP_SHIFT +: CHAN_W];
        end
    end

    assign b3_rdy  = !r_b3_v || i_pop;
    assign b2_rdy  = !r_b2_v || b3_rdy;
    assign b1_rdy  = !r_b1_v || b2_rdy;
    assign o_q_pop = !i_q_empty && b1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
        end else begin
            if (b1_rdy) begin
                r_b1_v <= !i_q_empty;
            end
            if (b2_rdy) begin
                r_b2_v <= r_b1_v;
            end
            if (b3_rdy) begin
                r_b3_v <= r_b2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b1_rdy) begin
            r_b1_rsum  <= n_rsum;
            r_b1_recip <= f_recip(cnt);
            r_b1_last  <= i_q_item.edges.last;
        end
        if (b2_rdy) begin
            r_b2_total <= n_total;
            r_b2_recip <= r_b1_recip;
            r_b2_last  <= r_b1_last;
        end
        if (b3_rdy) begin
            r_b3_pix  <= t_pix'(quot);
            r_b3_last <= r_b2_last;
        end
    end

    assign o_pix   = r_b3_pix;
    assign o_last  = r_b3_last;
    assign o_empty = !r_b3_v;

endmodule
